### src/assert_macros.svh
// Assertion helpers used by the filter unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/lbpf_pkg.sv
`timescale 1ns / 1ps
package lbpf_pkg;

  localparam int MAX_WIDTH_DEFAULT = 4096;
  localparam int STORED_LINES      = 4;
  localparam int LINE_LIMIT        = 4096;
  localparam int PIX_W             = 8;
  localparam int POS_W             = 12;
  localparam int DIM_W             = 13;
  localparam int MEM_W             = PIX_W * STORED_LINES;

  localparam logic [PIX_W-1:0] NONUNIFORM_CODE = 8'd9;
  localparam logic [DIM_W-1:0] DIM_MIN         = 13'd5;
  localparam logic [DIM_W-1:0] HEIGHT_MAX      = 13'd4096;
  localparam logic [DIM_W-1:0] WIDTH_RESET     = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET    = 13'd480;

  typedef enum logic [1:0] {
    MODE_STANDARD = 2'd0,
    MODE_MODIFIED = 2'd1,
    MODE_UNIFORM  = 2'd2,
    MODE_OFF      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_PATTERN_MODE  = 2'd0,
    REG_WINDOW_SELECT = 2'd1,
    REG_IMAGE_WIDTH   = 2'd2,
    REG_IMAGE_HEIGHT  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pattern_code;
    logic [POS_W-1:0] centre_column;
    logic [POS_W-1:0] centre_row;
    logic             frame_done;
  } out_item_t;

  typedef struct packed {
    mode_t mode;
    logic  wide;
  } pattern_cfg_t;

  // [row][column], column 4 is the newest
  typedef logic [4:0][4:0][PIX_W-1:0] window_t;

  // Ring offsets, neighbor p in bit p
  localparam int RING_SMALL_DX  [8] = '{-1,  0,  1,  1,  1,  0, -1, -1};
  localparam int RING_SMALL_DY  [8] = '{-1, -1, -1,  0,  1,  1,  1,  0};
  localparam int RING_SPARSE_DX [8] = '{-1,  0,  1,  2,  1,  0, -1, -2};
  localparam int RING_SPARSE_DY [8] = '{-1, -2, -1,  0,  1,  2,  1,  0};
  localparam int RING_WIDE_DX   [8] = '{-2,  0,  2,  2,  2,  0, -2, -2};
  localparam int RING_WIDE_DY   [8] = '{-2, -2, -2,  0,  2,  2,  2,  0};

endpackage

### src/lbpf_line_mem.sv
`timescale 1ns / 1ps
module lbpf_line_mem #(
  parameter int DEPTH = lbpf_pkg::MAX_WIDTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [lbpf_pkg::MEM_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [lbpf_pkg::MEM_W-1:0] wr_data
);

  // One word per column, one byte per stored line
  logic [lbpf_pkg::MEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/lbpf_window.sv
`timescale 1ns / 1ps
module lbpf_window (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        shift,
  input  logic [3:0][lbpf_pkg::PIX_W-1:0]             col_lines,
  input  logic [lbpf_pkg::PIX_W-1:0]                  pixel,
  output lbpf_pkg::window_t                           window
);

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (shift) begin
      for (int y = 0; y < 5; y++) begin
        for (int x = 0; x < 4; x++) begin
          window[y][x] <= window[y][x+1];
        end
      end
      for (int y = 0; y < 4; y++) begin
        window[y][4] <= col_lines[y];
      end
      window[4][4] <= pixel;
    end
  end

endmodule

### src/lbpf_code.sv
`timescale 1ns / 1ps
module lbpf_code (
  input  lbpf_pkg::window_t          window,
  input  lbpf_pkg::pattern_cfg_t     cfg,
  output logic [lbpf_pkg::PIX_W-1:0] code
);

  logic [lbpf_pkg::PIX_W-1:0] g_small  [8];
  logic [lbpf_pkg::PIX_W-1:0] g_sparse [8];
  logic [lbpf_pkg::PIX_W-1:0] g_wide   [8];
  logic [10:0]                sum;
  logic [lbpf_pkg::PIX_W-1:0] avg;
  logic [lbpf_pkg::PIX_W-1:0] centre;
  logic [7:0]                 mean_bits;
  logic [7:0]                 ring_bits;
  logic [3:0]                 trans;
  logic                       rad2;

  always_comb begin
    for (int p = 0; p < 8; p++) begin
      g_small[p]  = window[3'(3 + lbpf_pkg::RING_SMALL_DY[p])]
                          [3'(3 + lbpf_pkg::RING_SMALL_DX[p])];
      g_sparse[p] = window[3'(2 + lbpf_pkg::RING_SPARSE_DY[p])]
                          [3'(2 + lbpf_pkg::RING_SPARSE_DX[p])];
      g_wide[p]   = window[3'(2 + lbpf_pkg::RING_WIDE_DY[p])]
                          [3'(2 + lbpf_pkg::RING_WIDE_DX[p])];
    end
  end

  // Mean of the eight distance-2 points as (sum + 1) / 8, truncated
  always_comb begin
    sum = 11'd1;
    for (int p = 0; p < 8; p++) begin
      sum = sum + 11'(g_wide[p]);
    end
    avg = sum[10:3];
    for (int p = 0; p < 8; p++) begin
      mean_bits[p] = g_wide[p] > avg;
    end
  end

  always_comb begin
    rad2   = cfg.wide;
    centre = rad2 ? window[2][2] : window[3][3];
    for (int p = 0; p < 8; p++) begin
      ring_bits[p] = rad2 ? (g_sparse[p] >= centre) : (g_small[p] >= centre);
    end
    trans = 4'($countones(ring_bits ^ {ring_bits[6:0], ring_bits[7]}));
  end

  always_comb begin
    unique case (cfg.mode)
      lbpf_pkg::MODE_MODIFIED: code = mean_bits;
      lbpf_pkg::MODE_UNIFORM:  code = (trans > 4'd2) ? lbpf_pkg::NONUNIFORM_CODE : ring_bits;
      lbpf_pkg::MODE_STANDARD: code = ring_bits;
      default:                 code = ring_bits;
    endcase
  end

endmodule

### src/local_binary_pattern_filter_unit.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  in_item  (pixel_value, frame_start)
// out      output     out_valid/ out_ready out_item (pattern_code, centre_column,
//                                                    centre_row, frame_done)
// cfg      input      cfg_write            cfg_index, cfg_data
//
// One pixel per cycle unless the output stalls; a code passes stage 1, stage 2, output.
// The rate is set by the line memory: one read and one write of a column word
// per pixel, with the last write forwarded when the next pixel hits the same column.
// Reset clears counters, window and pipeline valids; the line memory is not cleared.
// A stalled output holds the pipeline back; pixels that give no code still pass.
`include "assert_macros.svh"
module local_binary_pattern_filter_unit #(
  parameter int MAX_WIDTH = lbpf_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lbpf_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lbpf_pkg::out_item_t             out_item,
  input  logic                            cfg_write,
  input  logic [1:0]                      cfg_index,
  input  logic [lbpf_pkg::DIM_W-1:0]      cfg_data
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WMAX = (MAX_WIDTH < lbpf_pkg::LINE_LIMIT) ? MAX_WIDTH : lbpf_pkg::LINE_LIMIT;
  localparam int PW   = lbpf_pkg::PIX_W;
  localparam int QW   = lbpf_pkg::POS_W;
  localparam int DW   = lbpf_pkg::DIM_W;

  // Configuration
  lbpf_pkg::mode_t pattern_mode;
  logic            window_select;
  logic [DW-1:0]   image_width;
  logic [DW-1:0]   image_height;
  logic [DW-1:0]   w_eff;
  logic [DW-1:0]   h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode  <= lbpf_pkg::MODE_STANDARD;
      window_select <= 1'b0;
      image_width   <= lbpf_pkg::WIDTH_RESET;
      image_height  <= lbpf_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (lbpf_pkg::reg_index_t'(cfg_index))
        lbpf_pkg::REG_PATTERN_MODE:  pattern_mode  <= lbpf_pkg::mode_t'(cfg_data[1:0]);
        lbpf_pkg::REG_WINDOW_SELECT: window_select <= cfg_data[0];
        lbpf_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        lbpf_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (image_width < lbpf_pkg::DIM_MIN) w_eff = lbpf_pkg::DIM_MIN;
    else if (image_width > DW'(WMAX))            w_eff = DW'(WMAX);
    else                                          w_eff = image_width;
    priority if (image_height < lbpf_pkg::DIM_MIN) h_eff = lbpf_pkg::DIM_MIN;
    else if (image_height > lbpf_pkg::HEIGHT_MAX)  h_eff = lbpf_pkg::HEIGHT_MAX;
    else                                            h_eff = image_height;
  end

  lbpf_pkg::pattern_cfg_t pcfg;
  assign pcfg.mode = pattern_mode;
  assign pcfg.wide = (pattern_mode == lbpf_pkg::MODE_MODIFIED) || window_select;

  // Pipeline control
  logic accept;
  logic s1v, s1_go, s1_free;
  logic s2v, s2_go, s2_free, s2_emit;
  logic out_free;

  // Position counters
  logic [QW-1:0] col_count, row_count;
  logic [QW-1:0] c_in, r_in;
  logic [DW-1:0] c_inc, r_inc;
  logic          wrap_col, wrap_row;
  logic [AW-1:0] rd_addr;

  assign accept = in_valid && in_ready;
  assign c_in   = in_item.frame_start ? '0 : col_count;
  assign r_in   = in_item.frame_start ? '0 : row_count;
  assign c_inc  = DW'(c_in) + DW'(1);
  assign r_inc  = DW'(r_in) + DW'(1);
  assign wrap_col = c_inc >= w_eff;
  assign wrap_row = r_inc >= h_eff;
  // Columns past the store land on its last column
  assign rd_addr = (32'(c_in) >= 32'(MAX_WIDTH)) ? AW'(MAX_WIDTH - 1) : AW'(c_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (wrap_col) begin
        col_count <= '0;
        row_count <= wrap_row ? '0 : r_inc[QW-1:0];
      end else begin
        col_count <= c_inc[QW-1:0];
        row_count <= r_in;
      end
    end
  end

  // Stage 1: memory word arrives, merge the new pixel and write back
  logic [QW-1:0]                s1_col, s1_row;
  logic                         s1_last;
  logic [PW-1:0]                s1_pix;
  logic [AW-1:0]                s1_addr;
  logic                         fwd_hit;
  logic [lbpf_pkg::MEM_W-1:0]   fwd_word;
  logic [lbpf_pkg::MEM_W-1:0]   rd_data;
  logic [lbpf_pkg::MEM_W-1:0]   cur_word;
  logic [lbpf_pkg::MEM_W-1:0]   wr_word;
  logic [3:0][PW-1:0]           col_lines;

  always_comb begin
    cur_word = fwd_hit ? fwd_word : rd_data;
    wr_word  = cur_word;
    wr_word[s1_row[1:0]*PW +: PW] = s1_pix;
    // Line slot wraps modulo the four stored lines
    for (int y = 0; y < 4; y++) begin
      col_lines[y] = cur_word[2'(2'(y) + s1_row[1:0])*PW +: PW];
    end
  end

  lbpf_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (s1_go),
    .wr_addr (s1_addr),
    .wr_data (wr_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v     <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (accept) begin
        s1v <= 1'b1;
        // Memory returns the old word when the write lands on the same edge
        fwd_hit <= s1_go && (s1_addr == rd_addr);
      end else if (s1_go) begin
        s1v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= c_in;
      s1_row   <= r_in;
      s1_last  <= wrap_col && wrap_row;
      s1_pix   <= in_item.pixel_value;
      s1_addr  <= rd_addr;
      fwd_word <= wr_word;
    end
  end

  // Stage 2: window holds the item's neighborhood, code is computed
  lbpf_pkg::window_t window;
  logic [PW-1:0]     code;
  logic [QW-1:0]     s2_col, s2_row;
  logic              s2_last;
  logic [QW-1:0]     rad;

  lbpf_window u_window (
    .clk       (clk),
    .rst       (rst),
    .shift     (s1_go),
    .col_lines (col_lines),
    .pixel     (s1_pix),
    .window    (window)
  );

  lbpf_code u_code (
    .window (window),
    .cfg    (pcfg),
    .code   (code)
  );

  assign rad     = pcfg.wide ? QW'(2) : QW'(1);
  assign s2_emit = (pattern_mode != lbpf_pkg::MODE_OFF) &&
                   (s2_col >= (rad << 1)) && (s2_row >= (rad << 1));

  assign out_free = !out_valid || out_ready;
  assign s2_go    = s2v && (!s2_emit || out_free);
  assign s2_free  = !s2v || s2_go;
  assign s1_go    = s1v && s2_free;
  assign s1_free  = !s1v || s1_go;
  assign in_ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2v <= 1'b0;
    end else if (s1_go) begin
      s2v <= 1'b1;
    end else if (s2_go) begin
      s2v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_col  <= s1_col;
      s2_row  <= s1_row;
      s2_last <= s1_last;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_go && s2_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_emit) begin
      out_item.pattern_code  <= code;
      out_item.centre_column <= s2_col - rad;
      out_item.centre_row    <= s2_row - rad;
      out_item.frame_done    <= s2_last;
    end
  end

  `ASSERT_NEXT(a_rst_clears_out, clk, 1'b0, rst, !out_valid)
  `ASSERT_IMPLIES(a_code_not_border, clk, rst, out_valid, (out_item.centre_column != '0) && (out_item.centre_row != '0))
  `ASSERT_NEXT(a_frame_start_origin, clk, rst, accept && in_item.frame_start, (s1_col == '0) && (s1_row == '0))
  `ASSERT_IMPLIES(a_stall_blocks_input, clk, rst, s1v && !s2_free, !in_ready)

endmodule
